/* design/hcbf_pkg.sv */
// Shared types, codes and character helpers for the chunked body framer.
`timescale 1ns / 1ps

package hcbf_pkg;

    localparam int LEN_W  = 31;
    localparam int BYTE_W = 8;
    localparam int CMD_STEP_W = 4;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_END   = 2'd2
    } t_action;

    // Work kinds handed from the front to the back
    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_HEX  = 2'd1,
        K_END  = 2'd2
    } t_kind;

    // Status codes carried on each output beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // Configuration register indexes and reset values
    localparam logic REG_CHUNKED_MODE = 1'b0;
    localparam logic MODE_RESET       = 1'b1;

    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [1:0]         status;
        logic [LEN_W-1:0]   length;
        logic               crlf;
        logic               fin;
    } t_cmd;

    // Lower-case hex character of one nibble
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10) begin
            r = CHAR_ZERO + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

    // Closing sequence: CR LF, then the zero chunk 0 CR LF CR LF
    function automatic logic [BYTE_W-1:0] end_char(input logic [2:0] step);
        logic [BYTE_W-1:0] r;
        unique case (step)
            3'd0:    r = CHAR_CR;
            3'd1:    r = CHAR_LF;
            3'd2:    r = CHAR_ZERO;
            3'd3:    r = CHAR_CR;
            3'd4:    r = CHAR_LF;
            3'd5:    r = CHAR_CR;
            default: r = CHAR_LF;
        endcase
        return r;
    endfunction

    // Count leading zero nibbles, keeping at least one digit
    function automatic logic [2:0] lead_zero_nibbles(input logic [LEN_W-1:0] len);
        logic [31:0] v;
        logic [2:0]  lz;
        logic        found;
        v     = {1'b0, len};
        lz    = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 1; i--) begin
            if (!found && v[4*i +: 4] == 4'd0) begin
                lz = lz + 3'd1;
            end else begin
                found = 1'b1;
            end
        end
        return lz;
    endfunction

endpackage

/* design/hcbf_ifs.sv */
// Valid/ready channel interfaces for the framer input and output beats.
`timescale 1ns / 1ps

interface hcbf_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic [hcbf_pkg::LEN_W-1:0]          chunk_length;
    logic [hcbf_pkg::BYTE_W-1:0]         data_byte;
    logic                                final_flag;

    modport source (output valid, action, chunk_length, data_byte, final_flag,
                    input ready);
    modport sink   (input valid, action, chunk_length, data_byte, final_flag,
                    output ready);
endinterface

interface hcbf_out_if;
    logic                                valid;
    logic                                ready;
    logic [hcbf_pkg::BYTE_W-1:0]         out_byte;
    logic                                run_last;
    logic [1:0]                          status;

    modport source (output valid, out_byte, run_last, status, input ready);
    modport sink   (input valid, out_byte, run_last, status, output ready);
endinterface

/* design/hcbf_front.sv */
// Front end: accepts input beats, tracks the chunk count and issues work.
`timescale 1ns / 1ps

module hcbf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hcbf_in_if.sink            i_in,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_q_full,
    output logic               o_push,
    output hcbf_pkg::t_cmd     o_cmd,
    output logic               o_mode
);

    logic                          r_mode;
    logic                          r_declared_nz;
    logic [hcbf_pkg::LEN_W-1:0]    r_remaining;
    logic                          n_declared_nz;
    logic [hcbf_pkg::LEN_W-1:0]    n_remaining;
    logic                          accept;
    logic                          rem_nz;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign rem_nz     = (r_remaining != '0);
    assign o_mode     = r_mode;

    // Classify the beat and work out the next count
    always_comb begin
        n_declared_nz = r_declared_nz;
        n_remaining   = r_remaining;
        o_push        = 1'b0;
        o_cmd.kind    = hcbf_pkg::K_DATA;
        o_cmd.data    = i_in.data_byte;
        o_cmd.status  = hcbf_pkg::ST_OK;
        o_cmd.length  = i_in.chunk_length;
        o_cmd.crlf    = r_declared_nz;
        o_cmd.fin     = i_in.final_flag;
        unique case (i_in.action)
            hcbf_pkg::ACT_BEGIN: begin
                o_cmd.kind = hcbf_pkg::K_HEX;
                if (r_mode) begin
                    n_remaining   = i_in.chunk_length;
                    n_declared_nz = (i_in.chunk_length != '0);
                    o_push        = accept && (i_in.chunk_length != '0);
                end
            end
            hcbf_pkg::ACT_DATA: begin
                o_push = accept;
                if (r_mode) begin
                    if (rem_nz) begin
                        n_remaining = r_remaining - 1'b1;
                    end else begin
                        o_cmd.status = hcbf_pkg::ST_OVER;
                    end
                end
            end
            hcbf_pkg::ACT_END: begin
                o_cmd.kind    = hcbf_pkg::K_END;
                o_cmd.status  = rem_nz ? hcbf_pkg::ST_SHORT : hcbf_pkg::ST_OK;
                o_push        = accept && r_mode && (r_declared_nz || i_in.final_flag);
                n_declared_nz = 1'b0;
                n_remaining   = '0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // Advance the chunk state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declared_nz <= 1'b0;
            r_remaining   <= '0;
        end else if (accept) begin
            r_declared_nz <= n_declared_nz;
            r_remaining   <= n_remaining;
        end
    end

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hcbf_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    a_rem_implies_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remaining != '0) |-> r_declared_nz)
        else $error("bytes remain with no open chunk");

    a_push_in_chunked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.kind != hcbf_pkg::K_DATA) |-> r_mode)
        else $error("framing work issued in identity mode");

endmodule

/* design/hcbf_queue.sv */
// Short work queue between the front and the back.
`timescale 1ns / 1ps

module hcbf_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hcbf_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output hcbf_pkg::t_cmd     o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hcbf_pkg::t_cmd       r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

endmodule

/* design/hcbf_back.sv */
// Back end: expands queued work into output bytes behind an output register.
`timescale 1ns / 1ps

module hcbf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  hcbf_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    hcbf_out_if.source         o_out
);

    logic                               r_busy;
    hcbf_pkg::t_kind                    r_kind;
    logic [hcbf_pkg::BYTE_W-1:0]        r_data;
    logic [1:0]                         r_status;
    logic [31:0]                        r_sh;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    r_step;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    r_last_step;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    r_ndig;
    logic                               r_ovalid;
    logic [hcbf_pkg::BYTE_W-1:0]        r_obyte;
    logic                               r_olast;
    logic [1:0]                         r_ostatus;

    logic                               can_adv;
    logic                               emit;
    logic                               is_last;
    logic [hcbf_pkg::BYTE_W-1:0]        cur_byte;
    logic [2:0]                         lz;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    n_step;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    n_last_step;
    logic [hcbf_pkg::CMD_STEP_W-1:0]    n_ndig;

    assign can_adv = !r_ovalid || o_out.ready;
    assign emit    = r_busy && can_adv;
    assign is_last = (r_step == r_last_step);
    assign o_pop   = i_q_valid && (!r_busy || (emit && is_last));
    assign lz      = hcbf_pkg::lead_zero_nibbles(i_cmd.length);

    // Pick the byte for the current step
    always_comb begin
        unique case (r_kind)
            hcbf_pkg::K_DATA: cur_byte = r_data;
            hcbf_pkg::K_HEX: begin
                if (r_step < r_ndig) begin
                    cur_byte = hcbf_pkg::hex_char(r_sh[31:28]);
                end else if (r_step == r_ndig) begin
                    cur_byte = hcbf_pkg::CHAR_CR;
                end else begin
                    cur_byte = hcbf_pkg::CHAR_LF;
                end
            end
            default: cur_byte = hcbf_pkg::end_char(r_step[2:0]);
        endcase
    end

    // Work out step range of the incoming work
    always_comb begin
        n_ndig = hcbf_pkg::CMD_STEP_W'(4'd8 - {1'b0, lz});
        unique case (i_cmd.kind)
            hcbf_pkg::K_DATA: begin
                n_step      = '0;
                n_last_step = '0;
            end
            hcbf_pkg::K_HEX: begin
                n_step      = '0;
                n_last_step = n_ndig + 1'b1;
            end
            default: begin
                n_step      = i_cmd.crlf ? 4'd0 : 4'd2;
                n_last_step = i_cmd.fin  ? 4'd6 : 4'd1;
            end
        endcase
    end

    // Load work, step through it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind      <= i_cmd.kind;
            r_data      <= i_cmd.data;
            r_status    <= i_cmd.status;
            r_sh        <= {1'b0, i_cmd.length} << {lz, 2'b00};
            r_step      <= n_step;
            r_last_step <= n_last_step;
            r_ndig      <= n_ndig;
        end else if (emit) begin
            r_step <= r_step + 1'b1;
            r_sh   <= {r_sh[27:0], 4'd0};
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (can_adv) begin
            r_ovalid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte   <= cur_byte;
            r_olast   <= is_last;
            r_ostatus <= r_status;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.run_last = r_olast;
    assign o_out.status   = r_ostatus;

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= r_last_step))
        else $error("sequencer step past the end of its work");

    a_hex_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_kind == hcbf_pkg::K_HEX) |-> (r_ndig >= 4'd1 && r_ndig <= 4'd8))
        else $error("hex digit count out of range");

endmodule

/* design/http_chunked_body_framer_top.sv */
// Top level of the HTTP chunked body framer.
//
//  channel   dir   handshake       payload
//  i_in      in    valid/ready     action, chunk_length, data_byte, final_flag
//  o_out     out   valid/ready     out_byte, run_last, status
//  APB       in    psel/penable    chunked_mode at byte address 0
//
// While the output is not stalled, a data beat produces one output byte, back to back,
// at one beat per cycle, and a begin beat up to ten framing bytes and an end beat up to
// seven, one per cycle from the back-end sequencer; the front keeps accepting while the
// queue has room. Work passes the queue, back-end registers and output register.
// Reset is synchronous, active low; the mode resets to chunked.
// An output stall fills the queue and then drops i_in.ready.
`timescale 1ns / 1ps

module http_chunked_body_framer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcbf_in_if.sink       i_in,
    hcbf_out_if.source    o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic               cfg_we;
    logic               mode;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    hcbf_pkg::t_cmd     push_cmd;
    hcbf_pkg::t_cmd     head_cmd;

    // Decode the register write and readback
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2] == hcbf_pkg::REG_CHUNKED_MODE);
    assign prdata = (paddr[2] == hcbf_pkg::REG_CHUNKED_MODE) ? {31'd0, mode} : 32'd0;

    hcbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (pwdata[0]),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_mode      (mode)
    );

    hcbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    hcbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* verif/tb_http_chunked_body_framer_top.sv */
// Self-checking testbench of the chunked body framer: directed table, random chunks, stalls.
`timescale 1ns / 1ps

module tb_http_chunked_body_framer_top;

    localparam int          CLK_HALF_NS  = 2;
    localparam int          RESET_CYCLES = 5;
    localparam int          SETTLE       = 10;
    localparam int          STALL_CYCLES = 64;
    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;

    typedef enum {ROW_ITEM, ROW_TYPED, ROW_MODE} t_row_kind;

    // One row of stimulus; typed rows carry their framed text right-aligned in txt
    typedef struct {
        t_row_kind                      kind;
        logic [1:0]                     act;
        logic [hcbf_pkg::LEN_W-1:0]     len;
        logic [hcbf_pkg::BYTE_W-1:0]    dat;
        logic                           fin;
        int                             n;
        logic [79:0]                    txt;
        logic [1:0]                     st;
        logic                           mode_val;
    } t_stim_row;

    typedef struct packed {
        logic [hcbf_pkg::BYTE_W-1:0]    chr;
        logic                           is_last;
        logic [1:0]                     st;
    } t_framed_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hcbf_in_if  in_if();
    hcbf_out_if out_if();

    http_chunked_body_framer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Shadow of the framer state and configuration
    logic                           mode_chunked = 1'b1;
    logic [hcbf_pkg::LEN_W-1:0]     open_len     = '0;
    logic [hcbf_pkg::LEN_W-1:0]     left_len     = '0;

    t_framed_beat       step_beats[$];
    t_framed_beat       pending_bytes[$];

    int  err_count   = 0;
    int  items_sent  = 0;
    int  beats_seen  = 0;
    int  mode_writes = 0;
    bit  quiet       = 1'b0;
    bit  stall_req   = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        err_count++;
    endtask

    function automatic void add_beat(input logic [hcbf_pkg::BYTE_W-1:0] chr,
                                     input logic [1:0] st);
        step_beats.push_back(t_framed_beat'{chr, 1'b0, st});
    endfunction

    // Work out the framed bytes of one accepted beat and advance the shadow state
    function automatic void predict_framing(input logic [1:0] act,
                                            input logic [hcbf_pkg::LEN_W-1:0] len,
                                            input logic [hcbf_pkg::BYTE_W-1:0] dat,
                                            input logic fin);
        logic [31:0] wide;
        logic [3:0]  nib;
        logic [1:0]  st;
        int          top;
        step_beats.delete();
        case (act)
            hcbf_pkg::ACT_BEGIN: begin
                if (mode_chunked) begin
                    open_len = len;
                    left_len = len;
                    if (len != '0) begin
                        // Hex digits from the first nonzero nibble down
                        wide = {1'b0, len};
                        top  = 7;
                        while (top > 0 && wide[4*top +: 4] == 4'd0) top--;
                        for (int k = top; k >= 0; k--) begin
                            nib = wide[4*k +: 4];
                            add_beat((nib < 4'd10) ? hcbf_pkg::CHAR_ZERO + {4'd0, nib}
                                                   : 8'h61 + {4'd0, nib} - 8'd10,
                                     hcbf_pkg::ST_OK);
                        end
                        add_beat(hcbf_pkg::CHAR_CR, hcbf_pkg::ST_OK);
                        add_beat(hcbf_pkg::CHAR_LF, hcbf_pkg::ST_OK);
                    end
                end
            end
            hcbf_pkg::ACT_DATA: begin
                st = hcbf_pkg::ST_OK;
                if (mode_chunked) begin
                    if (left_len == '0) begin
                        st = hcbf_pkg::ST_OVER;
                    end else begin
                        left_len = left_len - 1'b1;
                    end
                end
                add_beat(dat, st);
            end
            hcbf_pkg::ACT_END: begin
                if (mode_chunked) begin
                    st = (left_len != '0) ? hcbf_pkg::ST_SHORT : hcbf_pkg::ST_OK;
                    if (open_len != '0) begin
                        add_beat(hcbf_pkg::CHAR_CR, st);
                        add_beat(hcbf_pkg::CHAR_LF, st);
                    end
                    if (fin) begin
                        add_beat(hcbf_pkg::CHAR_ZERO, st);
                        add_beat(hcbf_pkg::CHAR_CR, st);
                        add_beat(hcbf_pkg::CHAR_LF, st);
                        add_beat(hcbf_pkg::CHAR_CR, st);
                        add_beat(hcbf_pkg::CHAR_LF, st);
                    end
                end
                open_len = '0;
                left_len = '0;
            end
            default: begin
            end
        endcase
        if (step_beats.size() != 0) step_beats[step_beats.size()-1].is_last = 1'b1;
    endfunction

    function automatic t_stim_row row_item(input logic [1:0] act,
                                           input logic [hcbf_pkg::LEN_W-1:0] len,
                                           input logic [hcbf_pkg::BYTE_W-1:0] dat,
                                           input logic fin);
        t_stim_row r;
        r = '{ROW_ITEM, act, len, dat, fin, 0, '0, hcbf_pkg::ST_OK, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row row_typed(input logic [1:0] act,
                                            input logic [hcbf_pkg::LEN_W-1:0] len,
                                            input logic [hcbf_pkg::BYTE_W-1:0] dat,
                                            input logic fin,
                                            input int n, input logic [79:0] txt,
                                            input logic [1:0] st);
        t_stim_row r;
        r = '{ROW_TYPED, act, len, dat, fin, n, txt, st, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row row_mode(input logic m);
        t_stim_row r;
        r = '{ROW_MODE, hcbf_pkg::ACT_BEGIN, '0, '0, 1'b0, 0, '0, hcbf_pkg::ST_OK, m};
        return r;
    endfunction

    // Offer one beat after a random gap, hold it until taken, then queue its bytes
    task automatic send_row(input t_stim_row r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= r.act;
        in_if.chunk_length <= r.len;
        in_if.data_byte    <= r.dat;
        in_if.final_flag   <= r.fin;
        do @(posedge i_clk); while (!in_if.ready);
        predict_framing(r.act, r.len, r.dat, r.fin);
        if (r.kind == ROW_TYPED) begin
            step_beats.delete();
            for (int k = 0; k < r.n; k++) begin
                step_beats.push_back(t_framed_beat'{r.txt[8*(r.n-1-k) +: 8],
                                                    (k == r.n - 1), r.st});
            end
        end
        foreach (step_beats[i]) pending_bytes.push_back(step_beats[i]);
        if (r.act != ACT_UNUSED) items_sent++;
    endtask

    // Drain, let the block settle, then write and read back the mode register
    task automatic set_mode(input logic m);
        in_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {hcbf_pkg::REG_CHUNKED_MODE, 2'b00};
        pwdata  <= {31'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mode_chunked = m;
        mode_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, m}) begin
            report_mismatch($sformatf("mode read back %h, wrote %0d", prdata, m));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One chunk with random content: mostly well formed, sometimes short, long or noisy
    task automatic send_random_chunk();
        logic [hcbf_pkg::LEN_W-1:0] len;
        int                         ndata;
        int                         pick;
        quiet = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, 19);
        if (pick == 0) begin
            len = '0;
        end else if (pick < 3) begin
            len = hcbf_pkg::LEN_W'($urandom);
        end else begin
            len = hcbf_pkg::LEN_W'($urandom_range(1, 8));
        end
        if (len > 8) begin
            ndata = $urandom_range(0, 3);
        end else begin
            ndata = int'(len);
            pick  = $urandom_range(0, 9);
            if (pick == 0) begin
                ndata++;
            end else if (pick == 1 && ndata > 0) begin
                ndata--;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            send_row(row_item(ACT_UNUSED, hcbf_pkg::LEN_W'($urandom),
                              hcbf_pkg::BYTE_W'($urandom), 1'($urandom)));
        end
        send_row(row_item(hcbf_pkg::ACT_BEGIN, len, hcbf_pkg::BYTE_W'($urandom),
                          1'($urandom)));
        repeat (ndata) begin
            send_row(row_item(hcbf_pkg::ACT_DATA, hcbf_pkg::LEN_W'($urandom),
                              hcbf_pkg::BYTE_W'($urandom), 1'($urandom)));
        end
        if ($urandom_range(0, 9) != 0) begin
            send_row(row_item(hcbf_pkg::ACT_END, hcbf_pkg::LEN_W'($urandom),
                              hcbf_pkg::BYTE_W'($urandom), 1'($urandom)));
        end
    endtask

    // Output side: random hold-offs, one long stall on request, check every beat
    initial begin : drain_output
        int           hold;
        t_framed_beat want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_req) begin
                hold      = STALL_CYCLES;
                stall_req = 1'b0;
            end else if (quiet) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 7);
            end
            if (hold != 0) begin
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            beats_seen++;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("output beat %h with nothing outstanding",
                                          out_if.out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (out_if.out_byte !== want.chr) begin
                    report_mismatch($sformatf("out_byte %h, want %h", out_if.out_byte, want.chr));
                end
                if (out_if.run_last !== want.is_last) begin
                    report_mismatch($sformatf("run_last %b, want %b on byte %h",
                                              out_if.run_last, want.is_last, want.chr));
                end
                if (out_if.status !== want.st) begin
                    report_mismatch($sformatf("status %0d, want %0d on byte %h",
                                              out_if.status, want.st, want.chr));
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row directed[$];
        int        directed_items;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.action        <= hcbf_pkg::ACT_BEGIN;
        in_if.chunk_length  <= '0;
        in_if.data_byte     <= '0;
        in_if.final_flag    <= 1'b0;
        out_if.ready        <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: typed rows carry their framed text, the rest use the predictor
        directed = '{
            // chunked after reset: stray byte, empty chunk, lone ends
            row_typed(hcbf_pkg::ACT_DATA,  31'd0, 8'h00, 1'b0, 1, 80'h00,
                      hcbf_pkg::ST_OVER),
            row_typed(hcbf_pkg::ACT_BEGIN, 31'd0, 8'h00, 1'b0, 0, 80'h0,
                      hcbf_pkg::ST_OK),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b0, 0, 80'h0,
                      hcbf_pkg::ST_OK),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b1, 5, "0\r\n\r\n",
                      hcbf_pkg::ST_OK),
            // longest length, ended short with the trailer
            row_typed(hcbf_pkg::ACT_BEGIN, 31'h7fffffff, 8'h00, 1'b0, 10, "7fffffff\r\n",
                      hcbf_pkg::ST_OK),
            row_item (hcbf_pkg::ACT_DATA,  31'd0, 8'hff, 1'b0),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b1, 7, "\r\n0\r\n\r\n",
                      hcbf_pkg::ST_SHORT),
            // one-byte chunk, then one byte too many
            row_typed(hcbf_pkg::ACT_BEGIN, 31'd1, 8'h00, 1'b0, 3, "1\r\n",
                      hcbf_pkg::ST_OK),
            row_item (hcbf_pkg::ACT_DATA,  31'd0, 8'ha5, 1'b0),
            row_typed(hcbf_pkg::ACT_DATA,  31'd0, 8'h5a, 1'b0, 1, 80'h5a,
                      hcbf_pkg::ST_OVER),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b0, 2, "\r\n",
                      hcbf_pkg::ST_OK),
            // begin over an open chunk drops it
            row_item (hcbf_pkg::ACT_BEGIN, 31'habcdef, 8'h00, 1'b0),
            row_item (hcbf_pkg::ACT_BEGIN, 31'h10,     8'h00, 1'b0),
            row_item (hcbf_pkg::ACT_DATA,  31'd0,      8'h3c, 1'b0),
            row_typed(ACT_UNUSED,          31'h7fffffff, 8'hff, 1'b1, 0, 80'h0,
                      hcbf_pkg::ST_OK),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b1, 7, "\r\n0\r\n\r\n",
                      hcbf_pkg::ST_SHORT),
            // mode change with a chunk open keeps the count
            row_item (hcbf_pkg::ACT_BEGIN, 31'd2, 8'h00, 1'b0),
            row_item (hcbf_pkg::ACT_DATA,  31'd0, 8'h01, 1'b0),
            row_mode (1'b0),
            row_typed(hcbf_pkg::ACT_DATA,  31'd0, 8'h80, 1'b0, 1, 80'h80,
                      hcbf_pkg::ST_OK),
            row_typed(hcbf_pkg::ACT_BEGIN, 31'd5, 8'h00, 1'b0, 0, 80'h0,
                      hcbf_pkg::ST_OK),
            row_mode (1'b1),
            row_item (hcbf_pkg::ACT_DATA,  31'd0, 8'h7e, 1'b0),
            row_typed(hcbf_pkg::ACT_BEGIN, 31'd3, 8'h00, 1'b0, 3, "3\r\n",
                      hcbf_pkg::ST_OK),
            // identity end still closes the chunk
            row_mode (1'b0),
            row_typed(hcbf_pkg::ACT_END,   31'd0, 8'h00, 1'b1, 0, 80'h0,
                      hcbf_pkg::ST_OK),
            row_mode (1'b1),
            row_typed(hcbf_pkg::ACT_DATA,  31'd0, 8'h11, 1'b0, 1, 80'h11,
                      hcbf_pkg::ST_OVER)
        };
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_MODE) begin
                set_mode(directed[i].mode_val);
            end else begin
                send_row(directed[i]);
            end
        end
        directed_items = items_sent;

        // Chunked: random well-formed chunks with some noise
        while (items_sent < directed_items + 55) send_random_chunk();

        // Identity: any action with random fields
        set_mode(1'b0);
        while (items_sent < directed_items + 75) begin
            quiet = ($urandom_range(0, 3) == 0);
            send_row(row_item(2'($urandom_range(0, 3)), hcbf_pkg::LEN_W'($urandom),
                              hcbf_pkg::BYTE_W'($urandom), 1'($urandom)));
        end

        // Chunked again, with one long output stall to back up the input
        set_mode(1'b1);
        stall_req = 1'b1;
        while (items_sent < directed_items + 110) send_random_chunk();

        in_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d body beats (%0d from the table), checked %0d framed bytes.",
                 items_sent, directed_items, beats_seen);
        $display("Covered both modes over %0d mode writes, short and overlong chunks, a long stall.",
                 mode_writes);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d framed bytes outstanding", pending_bytes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/hcbf_pkg.sv
design/hcbf_ifs.sv
design/hcbf_front.sv
design/hcbf_queue.sv
design/hcbf_back.sv
design/http_chunked_body_framer_top.sv
verif/tb_http_chunked_body_framer_top.sv
